/* hw/rtl/drsr_pkg.sv */
// Shared types and constants for the dual roller speed regulator.
`timescale 1ns / 1ps
`default_nettype none

package drsr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MAX  = 2'd1,
    CLAMP_ZERO = 2'd2
  } clamp_t;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_A  = 3'd0;
  localparam logic [2:0] REG_TARGET_B  = 3'd1;
  localparam logic [2:0] REG_DARK      = 3'd2;
  localparam logic [2:0] REG_REARM_A   = 3'd3;
  localparam logic [2:0] REG_REARM_B   = 3'd4;

  localparam int RPM_W   = 26;
  localparam int POWER_W = 13;
  localparam int DIFF_W  = 28;

  localparam logic [RPM_W-1:0]   RPM_NUMERATOR = 26'd60000000;
  localparam logic [POWER_W-1:0] POWER_MAX     = 13'd5100;
  localparam logic [POWER_W-1:0] POWER_RESET   = 13'd2400;
  localparam logic signed [POWER_W:0] POWER_MAX_S  = 14'sd5100;
  localparam logic signed [POWER_W:0] POWER_MIN_S  = 14'sd20;
  localparam logic signed [POWER_W:0] STEP_COARSE  = 14'sd100;
  localparam logic signed [POWER_W:0] STEP_MEDIUM  = 14'sd5;
  localparam logic signed [POWER_W:0] STEP_FINE    = 14'sd2;

  localparam logic signed [DIFF_W-1:0] DIFF_COARSE = 28'sd100;
  localparam logic signed [DIFF_W-1:0] DIFF_MEDIUM = 28'sd50;
  localparam logic signed [DIFF_W-1:0] DIFF_FINE   = 28'sd20;
  localparam logic [DIFF_W-1:0] BAND_TIGHT   = 28'd100;
  localparam logic [DIFF_W-1:0] BAND_LOOSE   = 28'd200;
  localparam logic [DIFF_W-1:0] HOLDOFF_DIFF = 28'd500;

  localparam logic [31:0] HOLDOFF_FAST_US = 32'd100000;
  localparam logic [31:0] HOLDOFF_SLOW_US = 32'd200000;

  // x / 5 as (x * 52429) >> 18, exact for x below 2^11
  localparam logic [15:0] RECIP_5 = 16'd52429;

endpackage

`default_nettype wire

/* hw/rtl/dual_roller_speed_regulator_core.sv */
// Dual roller speed regulator: edge timing, serial rpm division, power update.
//
// Each input transaction carries a timestamp and one optical sample per roller; only the
// active roller (A, then B, alternating) is examined. A sample that causes no speed update
// is taken while the block stays idle. A sample that closes a revolution starts a bit-serial
// restoring division of 60000000 by the period, one quotient bit per cycle, then the
// difference, power step and output load states; no further input is taken until the block
// is idle again, and it waits in the output load state while the previous result has not
// yet been taken from the output register. Inputs are accepted while a result waits.
// Configuration writes must be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module dual_roller_speed_regulator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // time_us[31:0], sample_a[41:32], sample_b[51:42]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // speed_rpm[25:0], power_level[38:26], pwm_drive[46:39], clamp_event[48:47],
  // converged[49]
  output logic [55:0]      m_tdata,
  output logic             m_tlast,   // round_done
  output logic             m_tuser,   // roller
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import drsr_pkg::*;

  // configuration
  logic [15:0] target_a, target_b;
  logic [9:0]  dark_threshold, rearm_a, rearm_b;

  // regulator state
  state_t state, state_next;
  logic        active_roller;
  logic [1:0]  armed;
  logic [31:0] start_time;
  logic        start_valid;
  logic [POWER_W-1:0] power_a, power_b;
  logic        a_in_band, locked_once;
  logic [31:0] holdoff_end;
  logic        holdoff_active;

  // work registers
  logic [31:0] t_reg;
  logic [31:0] period;
  logic        zero_period;
  logic [31:0] rem;
  logic [RPM_W-1:0] num_sh;
  logic [RPM_W-1:0] quo;
  logic [4:0]  div_cnt;
  logic signed [DIFF_W-1:0] diff;
  logic [POWER_W-1:0] p_new;
  clamp_t      clamp;
  logic        conv;

  // output register
  logic [RPM_W-1:0]   out_rpm;
  logic [POWER_W-1:0] out_power;
  logic [7:0]         out_pwm;
  clamp_t             out_clamp;
  logic               out_conv, out_roller;

  // input decode
  logic [31:0] t_in;
  logic [9:0]  s_sel, rearm_sel;
  logic [31:0] since_holdoff;
  logic        ignore, edge_hit, armed_next;
  logic        take, out_free;

  assign t_in          = s_tdata[31:0];
  assign s_sel         = active_roller ? s_tdata[51:42] : s_tdata[41:32];
  assign rearm_sel     = active_roller ? rearm_b : rearm_a;
  assign since_holdoff = t_in - holdoff_end;
  assign ignore        = holdoff_active && since_holdoff[31];
  assign edge_hit      = armed[active_roller] && (s_sel < dark_threshold);
  assign armed_next    = (s_sel > rearm_sel) ? 1'b1 : (edge_hit ? 1'b0 : armed[active_roller]);

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // one restoring division step
  logic [32:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem, num_sh[RPM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, period};

  // power step and clamp
  logic [DIFF_W-1:0]        ad;
  logic signed [POWER_W:0]  step, p_cur, p_sum;
  logic [POWER_W-1:0]       p_clamped;
  clamp_t                   clamp_calc;
  logic                     in_band;

  assign ad    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign p_cur = $signed({1'b0, (active_roller ? power_b : power_a)});
  assign p_sum = p_cur + step;
  assign in_band = locked_once ? (ad < BAND_LOOSE) : (ad < BAND_TIGHT);

  always_comb begin
    if (diff < -DIFF_COARSE) begin
      step = STEP_COARSE;
    end else if (diff > DIFF_COARSE) begin
      step = -STEP_COARSE;
    end else if (diff > DIFF_MEDIUM) begin
      step = -STEP_MEDIUM;
    end else if (diff < -DIFF_MEDIUM) begin
      step = STEP_MEDIUM;
    end else if (diff < -DIFF_FINE) begin
      step = STEP_FINE;
    end else if (diff > DIFF_FINE) begin
      step = -STEP_FINE;
    end else begin
      step = '0;
    end
  end

  always_comb begin
    // the zero clamp is tested first
    if (p_sum < POWER_MIN_S) begin
      p_clamped  = '0;
      clamp_calc = CLAMP_ZERO;
    end else if (p_sum > POWER_MAX_S) begin
      p_clamped  = POWER_MAX;
      clamp_calc = CLAMP_MAX;
    end else begin
      p_clamped  = p_sum[POWER_W-1:0];
      clamp_calc = CLAMP_NONE;
    end
  end

  // drive duty = (5100 - power) / 20
  logic [POWER_W-1:0] headroom;
  logic [26:0]        pwm_prod;
  assign headroom = POWER_MAX - p_new;
  assign pwm_prod = headroom[POWER_W-1:2] * RECIP_5;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && !ignore && edge_hit && start_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_STEP;
      ST_STEP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_a       <= 16'd800;
      target_b       <= 16'd800;
      dark_threshold <= 10'd500;
      rearm_a        <= 10'd500;
      rearm_b        <= 10'd900;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_A: target_a       <= cfg_data;
        REG_TARGET_B: target_b       <= cfg_data;
        REG_DARK:     dark_threshold <= cfg_data[9:0];
        REG_REARM_A:  rearm_a        <= cfg_data[9:0];
        REG_REARM_B:  rearm_b        <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_roller  <= 1'b0;
      armed          <= 2'b11;
      start_time     <= '0;
      start_valid    <= 1'b0;
      power_a        <= POWER_RESET;
      power_b        <= POWER_RESET;
      a_in_band      <= 1'b0;
      locked_once    <= 1'b0;
      holdoff_end    <= '0;
      holdoff_active <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take && !ignore) begin
            holdoff_active        <= 1'b0;
            armed[active_roller]  <= armed_next;
            if (edge_hit) begin
              if (!start_valid) begin
                start_time  <= t_in;
                start_valid <= 1'b1;
              end else begin
                start_valid <= 1'b0;
              end
            end
          end
        end
        ST_STEP: begin
          if (active_roller) begin
            power_b <= p_clamped;
            if (a_in_band && in_band) begin
              locked_once <= 1'b1;
            end
          end else begin
            power_a   <= p_clamped;
            a_in_band <= in_band;
          end
          holdoff_end    <= t_reg + ((ad > HOLDOFF_DIFF) ? HOLDOFF_FAST_US : HOLDOFF_SLOW_US);
          holdoff_active <= 1'b1;
          active_roller  <= !active_roller;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          t_reg       <= t_in;
          period      <= t_in - start_time;
          zero_period <= (t_in == start_time);
          rem         <= '0;
          num_sh      <= RPM_NUMERATOR;
          div_cnt     <= 5'(RPM_W - 1);
        end
      end
      ST_DIV: begin
        rem     <= rem_ge ? 32'(rem_sh - {1'b0, period}) : rem_sh[31:0];
        quo     <= {quo[RPM_W-2:0], rem_ge};
        num_sh  <= {num_sh[RPM_W-2:0], 1'b0};
        div_cnt <= div_cnt - 5'd1;
      end
      ST_DIFF: begin
        // a zero period saturates to the numerator
        if (zero_period) begin
          quo  <= RPM_NUMERATOR;
          diff <= $signed({2'b00, RPM_NUMERATOR})
                  - $signed({12'd0, (active_roller ? target_b : target_a)});
        end else begin
          diff <= $signed({2'b00, quo})
                  - $signed({12'd0, (active_roller ? target_b : target_a)});
        end
      end
      ST_STEP: begin
        p_new <= p_clamped;
        clamp <= clamp_calc;
        conv  <= active_roller && a_in_band && in_band;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_rpm    <= quo;
          out_power  <= p_new;
          out_pwm    <= pwm_prod[25:18];
          out_clamp  <= clamp;
          out_conv   <= conv;
          out_roller <= !active_roller;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {6'd0, out_conv, out_clamp, out_pwm, out_power, out_rpm};
  assign m_tlast = out_roller;
  assign m_tuser = out_roller;

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    (power_a <= POWER_MAX) && (power_b <= POWER_MAX))
    else $error("power above maximum");

  a_conv_on_b_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_conv) |-> out_roller)
    else $error("converged on a roller A result");

  a_roller_toggles: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |=> (active_roller != $past(active_roller)) && (state == ST_EMIT))
    else $error("active roller did not advance after update");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !s_tready && holdoff_active == $past(holdoff_active))
    else $error("input taken or hold-off changed during division");

  a_clamp_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_clamp != 2'd3))
    else $error("undefined clamp code");

endmodule

`default_nettype wire
